// File: rtl/core/chhc_pkg.sv
`default_nettype none

package chhc_pkg;

	// Field and register widths
	localparam int unsigned TickW   = 32;
	localparam int unsigned SpeedW  = 18;
	localparam int unsigned WordW   = 16;
	localparam int unsigned DirW    = 2;
	localparam int unsigned PhaseW  = 2;
	localparam int unsigned ModeW   = 2;
	localparam int unsigned SensorW = 3;
	localparam int unsigned HandN   = 3;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = SpeedW;

	// Register reset values
	localparam logic [SpeedW-1:0] HomingSpeedRst  = SpeedW'(250000);
	localparam logic [SpeedW-1:0] SecondsSpeedRst = SpeedW'(68270);
	localparam logic [SpeedW-1:0] MinutesSpeedRst = SpeedW'(1138);
	localparam logic [SpeedW-1:0] HoursSpeedRst   = SpeedW'(95);
	localparam logic [WordW-1:0]  BeepTicksRst    = WordW'(500);
	localparam logic [WordW-1:0]  ToneFreqRst     = WordW'(440);
	localparam logic [WordW-1:0]  CountPeriodRst  = WordW'(10);

	// Hand positions in the per-hand arrays and in the sensor bits
	localparam int unsigned HandSec  = 0;
	localparam int unsigned HandMin  = 1;
	localparam int unsigned HandHour = 2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_HOMING_SPEED  = 3'd0,
		REG_SECONDS_SPEED = 3'd1,
		REG_MINUTES_SPEED = 3'd2,
		REG_HOURS_SPEED   = 3'd3,
		REG_BEEP_TICKS    = 3'd4,
		REG_TONE_FREQ     = 3'd5,
		REG_COUNT_PERIOD  = 3'd6
	} reg_idx_t;

	typedef enum logic [DirW-1:0] {
		DIR_CW   = 2'd0,
		DIR_STOP = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// Codes of the phase as shown on the result
	localparam logic [PhaseW-1:0] PHASE_CODE_INIT   = 2'd0;
	localparam logic [PhaseW-1:0] PHASE_CODE_HOMING = 2'd1;
	localparam logic [PhaseW-1:0] PHASE_CODE_HOMED  = 2'd2;
	localparam logic [PhaseW-1:0] PHASE_CODE_RUN    = 2'd3;

	typedef enum logic [3:0] {
		PH_INIT   = 4'b0001,
		PH_HOMING = 4'b0010,
		PH_HOMED  = 4'b0100,
		PH_RUN    = 4'b1000
	} phase_t;

	function automatic logic [PhaseW-1:0] phase_code(input phase_t ph);
		logic [PhaseW-1:0] code;
		unique case (ph)
			PH_INIT:   code = PHASE_CODE_INIT;
			PH_HOMING: code = PHASE_CODE_HOMING;
			PH_HOMED:  code = PHASE_CODE_HOMED;
			PH_RUN:    code = PHASE_CODE_RUN;
			default:   code = PHASE_CODE_INIT;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/clock_hand_homing_controller.sv
// Clock hand homing controller. Each input transaction is one pass of the control
// loop: a tick count, three buttons, an optional photo-interrupter event with its
// three sensor bits and the display-mode switch. The block keeps the phase
// sequencer (init, homing, homed, running), the per-hand home flags, directions and
// speed words, the buzzer timer and the display counter, and returns one result
// transaction per input transaction. The work of a pass is a few compares and
// 32-bit subtracts, done in the cycle the input transaction is accepted; the state
// and the result register are written at that edge. A result therefore appears in the
// cycle after its input, and a new input transaction is taken every cycle as long
// as the result register is empty or is being drained in the same cycle, so the
// sustained rate is one transaction per clock. Configuration registers are written
// through cfg_wr_en, cfg_index and cfg_wr_data without a wait; indexes beyond the
// last register are ignored.
`default_nettype none

module clock_hand_homing_controller (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_wr_en,
	input  wire logic [chhc_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [chhc_pkg::CfgDataW-1:0]      cfg_wr_data,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [chhc_pkg::TickW-1:0]         tick_now,
	input  wire logic                               up_pressed,
	input  wire logic                               right_pressed,
	input  wire logic                               down_pressed,
	input  wire logic                               photo_event,
	input  wire logic [chhc_pkg::SensorW-1:0]       photo_bits,
	input  wire logic [chhc_pkg::ModeW-1:0]         display_select,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [chhc_pkg::DirW-1:0]               seconds_dir,
	output logic [chhc_pkg::DirW-1:0]               minutes_dir,
	output logic [chhc_pkg::DirW-1:0]               hours_dir,
	output logic [chhc_pkg::SpeedW-1:0]             seconds_speed_out,
	output logic [chhc_pkg::SpeedW-1:0]             minutes_speed_out,
	output logic [chhc_pkg::SpeedW-1:0]             hours_speed_out,
	output logic                                    buzzer_on,
	output logic [chhc_pkg::WordW-1:0]              buzzer_freq,
	output logic [chhc_pkg::TickW-1:0]              display_count,
	output logic [chhc_pkg::ModeW-1:0]              display_mode,
	output logic [chhc_pkg::PhaseW-1:0]             phase
);

	// Configuration registers.
	logic [chhc_pkg::SpeedW-1:0] homing_speed_q;
	logic [chhc_pkg::SpeedW-1:0] seconds_speed_q;
	logic [chhc_pkg::SpeedW-1:0] minutes_speed_q;
	logic [chhc_pkg::SpeedW-1:0] hours_speed_q;
	logic [chhc_pkg::WordW-1:0]  beep_ticks_q;
	logic [chhc_pkg::WordW-1:0]  tone_freq_q;
	logic [chhc_pkg::WordW-1:0]  count_period_q;

	// Controller state.
	chhc_pkg::phase_t             phase_q;
	logic [chhc_pkg::HandN-1:0]   home_q;
	chhc_pkg::dir_t               dir_q   [chhc_pkg::HandN];
	logic [chhc_pkg::SpeedW-1:0]  speed_q [chhc_pkg::HandN];
	logic                         beep_q;
	logic [chhc_pkg::TickW-1:0]   beep_start_q;
	logic [chhc_pkg::TickW-1:0]   last_count_q;
	logic [chhc_pkg::TickW-1:0]   count_q;

	// Result register.
	logic                         out_valid_q;
	chhc_pkg::dir_t               out_dir_q   [chhc_pkg::HandN];
	logic [chhc_pkg::SpeedW-1:0]  out_speed_q [chhc_pkg::HandN];
	logic                         out_beep_q;
	logic [chhc_pkg::WordW-1:0]   out_freq_q;
	logic [chhc_pkg::TickW-1:0]   out_count_q;
	logic [chhc_pkg::ModeW-1:0]   out_mode_q;
	logic [chhc_pkg::PhaseW-1:0]  out_phase_q;

	// Next-state values of one pass.
	logic                         accept;
	logic [chhc_pkg::HandN-1:0]   home_photo;
	logic                         beep_photo;
	logic                         all_stopped;
	chhc_pkg::phase_t             phase_d;
	logic [chhc_pkg::HandN-1:0]   home_d;
	chhc_pkg::dir_t               dir_d   [chhc_pkg::HandN];
	logic [chhc_pkg::SpeedW-1:0]  speed_d [chhc_pkg::HandN];
	logic [chhc_pkg::SpeedW-1:0]  run_speed [chhc_pkg::HandN];
	logic [chhc_pkg::TickW-1:0]   beep_elapsed;
	logic                         beep_d;
	logic [chhc_pkg::TickW-1:0]   beep_start_d;
	logic [chhc_pkg::TickW-1:0]   count_elapsed;
	logic                         count_due;
	logic [chhc_pkg::TickW-1:0]   last_count_d;
	logic [chhc_pkg::TickW-1:0]   count_d;

	// The result register frees up in the same cycle it is drained, so a full
	// register only stalls the input when the consumer is also stalling.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Configuration writes. Values wider than a register are truncated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homing_speed_q  <= chhc_pkg::HomingSpeedRst;
			seconds_speed_q <= chhc_pkg::SecondsSpeedRst;
			minutes_speed_q <= chhc_pkg::MinutesSpeedRst;
			hours_speed_q   <= chhc_pkg::HoursSpeedRst;
			beep_ticks_q    <= chhc_pkg::BeepTicksRst;
			tone_freq_q     <= chhc_pkg::ToneFreqRst;
			count_period_q  <= chhc_pkg::CountPeriodRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				chhc_pkg::REG_HOMING_SPEED:  homing_speed_q  <= cfg_wr_data;
				chhc_pkg::REG_SECONDS_SPEED: seconds_speed_q <= cfg_wr_data;
				chhc_pkg::REG_MINUTES_SPEED: minutes_speed_q <= cfg_wr_data;
				chhc_pkg::REG_HOURS_SPEED:   hours_speed_q   <= cfg_wr_data;
				chhc_pkg::REG_BEEP_TICKS:    beep_ticks_q    <= cfg_wr_data[chhc_pkg::WordW-1:0];
				chhc_pkg::REG_TONE_FREQ:     tone_freq_q     <= cfg_wr_data[chhc_pkg::WordW-1:0];
				chhc_pkg::REG_COUNT_PERIOD:  count_period_q  <= cfg_wr_data[chhc_pkg::WordW-1:0];
				default: ;
			endcase
		end
	end

	// Photo event first: it only matters while homing (home flags) or while
	// running (the seconds sensor triggers the buzzer).
	assign home_photo = home_q |
		((photo_event && phase_q == chhc_pkg::PH_HOMING) ? photo_bits : '0);
	assign beep_photo = beep_q ||
		(photo_event && phase_q == chhc_pkg::PH_RUN && photo_bits[chhc_pkg::HandSec]);

	// Homing ends on directions as the previous pass left them, not on the flags
	// just set, so there is always one pass with every hand at stop before homed.
	assign all_stopped = dir_q[chhc_pkg::HandSec]  == chhc_pkg::DIR_STOP &&
	                     dir_q[chhc_pkg::HandMin]  == chhc_pkg::DIR_STOP &&
	                     dir_q[chhc_pkg::HandHour] == chhc_pkg::DIR_STOP;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			chhc_pkg::PH_INIT:   if (up_pressed)    phase_d = chhc_pkg::PH_HOMING;
			chhc_pkg::PH_HOMING: if (all_stopped)   phase_d = chhc_pkg::PH_HOMED;
			chhc_pkg::PH_HOMED:  if (right_pressed) phase_d = chhc_pkg::PH_RUN;
			chhc_pkg::PH_RUN:    if (down_pressed)  phase_d = chhc_pkg::PH_INIT;
			default:             phase_d = chhc_pkg::PH_INIT;
		endcase
	end

	assign run_speed[chhc_pkg::HandSec]  = seconds_speed_q;
	assign run_speed[chhc_pkg::HandMin]  = minutes_speed_q;
	assign run_speed[chhc_pkg::HandHour] = hours_speed_q;

	// Motor drive follows the phase after this pass's update. In the homed
	// phase nothing is touched. A hand that reaches home stops but keeps its
	// speed word.
	always_comb begin
		home_d = home_photo;
		for (int h = 0; h < chhc_pkg::HandN; h++) begin
			dir_d[h]   = dir_q[h];
			speed_d[h] = speed_q[h];
			unique case (phase_d)
				chhc_pkg::PH_INIT: begin
					dir_d[h]  = chhc_pkg::DIR_STOP;
					home_d[h] = 1'b0;
				end
				chhc_pkg::PH_HOMING: begin
					if (!home_photo[h]) begin
						dir_d[h]   = chhc_pkg::DIR_CCW;
						speed_d[h] = homing_speed_q;
					end else begin
						dir_d[h] = chhc_pkg::DIR_STOP;
					end
				end
				chhc_pkg::PH_RUN: begin
					dir_d[h]   = chhc_pkg::DIR_CW;
					speed_d[h] = run_speed[h];
				end
				default: ;
			endcase
		end
	end

	// Buzzer timer. While silent the start tick tracks the tick count, so a
	// trigger measures from the last silent pass. Differences wrap mod 2^32.
	assign beep_elapsed = tick_now - beep_start_q;

	always_comb begin
		beep_d       = beep_photo;
		beep_start_d = beep_start_q;
		if (!beep_photo) begin
			beep_start_d = tick_now;
		end else if (beep_elapsed >= chhc_pkg::TickW'(beep_ticks_q)) begin
			beep_d = 1'b0;
		end
	end

	// Display counter. It runs only in the running phase and clears otherwise;
	// the tick of the last increment is kept across phases. A period of zero
	// always counts as elapsed.
	assign count_elapsed = tick_now - last_count_q;
	assign count_due     = count_elapsed >= chhc_pkg::TickW'(count_period_q);

	always_comb begin
		last_count_d = last_count_q;
		count_d      = '0;
		if (phase_d == chhc_pkg::PH_RUN) begin
			count_d = count_q;
			if (count_due) begin
				last_count_d = tick_now;
				count_d      = count_q + chhc_pkg::TickW'(1);
			end
		end
	end

	// State update on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= chhc_pkg::PH_INIT;
			home_q       <= '0;
			beep_q       <= 1'b0;
			beep_start_q <= '0;
			last_count_q <= '0;
			count_q      <= '0;
			for (int h = 0; h < chhc_pkg::HandN; h++) begin
				dir_q[h]   <= chhc_pkg::DIR_STOP;
				speed_q[h] <= '0;
			end
		end else if (accept) begin
			phase_q      <= phase_d;
			home_q       <= home_d;
			beep_q       <= beep_d;
			beep_start_q <= beep_start_d;
			last_count_q <= last_count_d;
			count_q      <= count_d;
			for (int h = 0; h < chhc_pkg::HandN; h++) begin
				dir_q[h]   <= dir_d[h];
				speed_q[h] <= speed_d[h];
			end
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result register: payload. The counter value shown is the one from
	// before this pass's update.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_beep_q  <= beep_d;
			out_freq_q  <= beep_d ? tone_freq_q : '0;
			out_count_q <= count_q;
			out_mode_q  <= display_select;
			out_phase_q <= chhc_pkg::phase_code(phase_d);
			for (int h = 0; h < chhc_pkg::HandN; h++) begin
				out_dir_q[h]   <= dir_d[h];
				out_speed_q[h] <= speed_d[h];
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign seconds_dir       = out_dir_q[chhc_pkg::HandSec];
	assign minutes_dir       = out_dir_q[chhc_pkg::HandMin];
	assign hours_dir         = out_dir_q[chhc_pkg::HandHour];
	assign seconds_speed_out = out_speed_q[chhc_pkg::HandSec];
	assign minutes_speed_out = out_speed_q[chhc_pkg::HandMin];
	assign hours_speed_out   = out_speed_q[chhc_pkg::HandHour];
	assign buzzer_on         = out_beep_q;
	assign buzzer_freq       = out_freq_q;
	assign display_count     = out_count_q;
	assign display_mode      = out_mode_q;
	assign phase             = out_phase_q;

endmodule

`default_nettype wire

// File: rtl/core/chhc_checker.sv
`default_nettype none

module chhc_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [chhc_pkg::DirW-1:0]      seconds_dir,
	input  wire logic [chhc_pkg::DirW-1:0]      minutes_dir,
	input  wire logic [chhc_pkg::DirW-1:0]      hours_dir,
	input  wire logic                           buzzer_on,
	input  wire logic [chhc_pkg::WordW-1:0]     buzzer_freq,
	input  wire logic [chhc_pkg::TickW-1:0]     display_count,
	input  wire logic [chhc_pkg::PhaseW-1:0]    phase
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) &&
			$stable(display_count) && $stable(buzzer_on))
		else $error("result changed while stalled");

	// A silent buzzer gets no frequency word.
	a_quiet_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !buzzer_on |-> buzzer_freq == '0)
		else $error("buzzer frequency set while silent");

	// In the init phase every hand is stopped.
	a_init_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == chhc_pkg::PHASE_CODE_INIT |->
			seconds_dir == chhc_pkg::DIR_STOP && minutes_dir == chhc_pkg::DIR_STOP &&
			hours_dir == chhc_pkg::DIR_STOP)
		else $error("hand moving in init phase");

	// In the running phase every hand turns clockwise.
	a_run_cw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == chhc_pkg::PHASE_CODE_RUN |->
			seconds_dir == chhc_pkg::DIR_CW && minutes_dir == chhc_pkg::DIR_CW &&
			hours_dir == chhc_pkg::DIR_CW)
		else $error("hand not clockwise in running phase");

endmodule

bind clock_hand_homing_controller chhc_checker u_chhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.seconds_dir   (seconds_dir),
	.minutes_dir   (minutes_dir),
	.hours_dir     (hours_dir),
	.buzzer_on     (buzzer_on),
	.buzzer_freq   (buzzer_freq),
	.display_count (display_count),
	.phase         (phase)
);

`default_nettype wire
